[src/checked_frame_deframer_assert.svh]
// assertion helpers for the checker file
`ifndef CHECKED_FRAME_DEFRAMER_ASSERT_SVH
`define CHECKED_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CFD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("checked_frame_deframer: same-cycle assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define CFD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("checked_frame_deframer: next-cycle assertion failed");

`endif

[src/cfd_pkg.sv]
`default_nettype none

package cfd_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 21;
	localparam int WORD_W = 32;
	localparam int STAT_W = 3;
	localparam int KIND_W = 2;
	localparam int SUM_W  = 16;

	localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_URL     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
	localparam logic [STAT_W-1:0] ST_CHECK = 3'd1;
	localparam logic [STAT_W-1:0] ST_LEN   = 3'd2;
	localparam logic [STAT_W-1:0] ST_LONG  = 3'd3;
	localparam logic [STAT_W-1:0] ST_HASH  = 3'd4;
	localparam logic [STAT_W-1:0] ST_SHORT = 3'd5;

	localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 21'd1048576;
	localparam logic [SUM_W-1:0]  ADLER_MOD     = 16'd65521;
	localparam logic [BYTE_W-1:0] MIN_HDR_LEN   = 8'd16;

	// one queued request: a result to deliver, plus what the back end needs for the hash
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [KIND_W-1:0] kind;
		logic              last;
		logic [STAT_W-1:0] status;
		logic              check_hash;
		logic [WORD_W-1:0] seq;
		logic [LEN_W-1:0]  len;
		logic [WORD_W-1:0] hash;
	} cmd_t;

endpackage

`default_nettype wire

[src/cfd_front.sv]
`default_nettype none

module cfd_front import cfd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic              cfg_wen,
	input  wire logic [LEN_W-1:0]  cfg_wdata,
	input  wire logic              q_full,
	output logic                   push,
	output cmd_t                   cmd
);

	localparam logic PH_HEADER = 1'b0;
	localparam logic PH_BODY   = 1'b1;

	logic              phase_q;
	logic [LEN_W-1:0]  pos_q;
	logic [BYTE_W-1:0] hl_q, ul_q, cb_q;
	logic [WORD_W-1:0] total_q, seq_q, hash_q;
	logic [LEN_W-1:0]  max_len_q;

	logic              accept;
	logic              hdr_end;
	logic [BYTE_W-1:0] sum8;
	logic [BYTE_W:0]   hu9;
	logic [BYTE_W:0]   url_end;
	logic [STAT_W-1:0] hdr_err;
	logic              len16;
	logic [WORD_W-1:0] hash_nx;
	logic [LEN_W:0]    pos_p1;
	logic              body_last;
	logic [KIND_W-1:0] body_kind;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign hdr_end  = (pos_q == 21'd15);

	// header checks, in priority order
	assign sum8 = hl_q + ul_q + total_q[BYTE_W-1:0];
	assign hu9  = {1'b0, hl_q} + {1'b0, ul_q};
	always_comb begin
		if (sum8 != cb_q) begin
			hdr_err = ST_CHECK;
		end else if ({23'd0, hu9} > total_q) begin
			hdr_err = ST_LEN;
		end else if (total_q > {11'd0, max_len_q}) begin
			hdr_err = ST_LONG;
		end else if (hl_q < MIN_HDR_LEN) begin
			hdr_err = ST_SHORT;
		end else begin
			hdr_err = ST_OK;
		end
	end
	assign len16 = (total_q == 32'd16);

	assign hash_nx = (phase_q == PH_HEADER && pos_q >= 21'd12) ?
		{hash_q[WORD_W-9:0], in_byte} : hash_q;

	// body classification; total fits 21 bits once the header passed
	assign url_end   = hu9;
	assign pos_p1    = {1'b0, pos_q} + 22'd1;
	assign body_last = (pos_p1 >= {1'b0, total_q[LEN_W-1:0]});
	always_comb begin
		if (pos_q < {13'd0, hl_q}) begin
			body_kind = KIND_STATUS;
		end else if (pos_q < {12'd0, url_end}) begin
			body_kind = KIND_URL;
		end else begin
			body_kind = KIND_PAYLOAD;
		end
	end

	always_comb begin
		cmd.seq  = seq_q;
		cmd.len  = total_q[LEN_W-1:0];
		cmd.hash = hash_nx;
		unique case (phase_q)
			PH_HEADER: begin
				cmd.data       = '0;
				cmd.kind       = KIND_STATUS;
				cmd.last       = 1'b1;
				cmd.status     = hdr_err;
				cmd.check_hash = (hdr_err == ST_OK);
				push           = accept && hdr_end && (hdr_err != ST_OK || len16);
			end
			PH_BODY: begin
				cmd.data       = (body_kind != KIND_STATUS) ? in_byte : '0;
				cmd.kind       = body_kind;
				cmd.last       = body_last;
				cmd.status     = ST_OK;
				cmd.check_hash = body_last;
				push           = accept && (body_last || body_kind != KIND_STATUS);
			end
			default: begin
				cmd.data       = '0;
				cmd.kind       = KIND_STATUS;
				cmd.last       = 1'b0;
				cmd.status     = ST_OK;
				cmd.check_hash = 1'b0;
				push           = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wen) begin
			max_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			hl_q    <= '0;
			ul_q    <= '0;
			cb_q    <= '0;
			total_q <= '0;
			seq_q   <= '0;
			hash_q  <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_HEADER: begin
					hash_q <= hash_nx;
					if (pos_q == 21'd0) begin
						cb_q <= in_byte;
					end
					if (pos_q == 21'd2) begin
						hl_q <= in_byte;
					end
					if (pos_q == 21'd3) begin
						ul_q <= in_byte;
					end
					if (pos_q >= 21'd4 && pos_q <= 21'd7) begin
						total_q <= {total_q[WORD_W-9:0], in_byte};
					end
					if (pos_q >= 21'd8 && pos_q <= 21'd11) begin
						seq_q <= {seq_q[WORD_W-9:0], in_byte};
					end
					if (!hdr_end) begin
						pos_q <= pos_p1[LEN_W-1:0];
					end else if (hdr_err != ST_OK || len16) begin
						pos_q <= '0;
					end else begin
						phase_q <= PH_BODY;
						pos_q   <= 21'd16;
					end
				end
				PH_BODY: begin
					if (body_last) begin
						phase_q <= PH_HEADER;
						pos_q   <= '0;
					end else begin
						pos_q <= pos_p1[LEN_W-1:0];
					end
				end
				default: begin
					phase_q <= PH_HEADER;
					pos_q   <= '0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[src/cfd_queue.sv]
`default_nettype none

module cfd_queue import cfd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wr_data,
	input  wire logic pop,
	output cmd_t      rd_data,
	output logic      full,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[src/cfd_back.sv]
`default_nettype none

module cfd_back import cfd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire cmd_t              head,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [BYTE_W-1:0]      out_byte,
	output logic [KIND_W-1:0]      byte_kind,
	output logic                   frame_end,
	output logic [STAT_W-1:0]      status,
	output logic [WORD_W-1:0]      frame_sequence,
	output logic [LEN_W-1:0]       frame_length
);

	logic [SUM_W-1:0] a_q, b_q;
	logic [SUM_W:0]   a_sum, b_sum;
	logic [SUM_W-1:0] a_nx, b_nx, a_new, b_new;
	logic             upd;
	logic             hash_bad;
	logic [STAT_W-1:0] st_nx;

	assign pop = !q_empty && (!out_valid || out_ready);
	assign upd = (head.kind != KIND_STATUS);

	// both sums stay below twice the modulus, so one subtract corrects
	assign a_sum = {1'b0, a_q} + {9'd0, head.data};
	assign a_nx  = (a_sum >= {1'b0, ADLER_MOD}) ?
		SUM_W'(a_sum - {1'b0, ADLER_MOD}) : a_sum[SUM_W-1:0];
	assign b_sum = {1'b0, b_q} + {1'b0, a_nx};
	assign b_nx  = (b_sum >= {1'b0, ADLER_MOD}) ?
		SUM_W'(b_sum - {1'b0, ADLER_MOD}) : b_sum[SUM_W-1:0];
	assign a_new = upd ? a_nx : a_q;
	assign b_new = upd ? b_nx : b_q;

	assign hash_bad = (head.hash != '0) && (head.hash != {b_new, a_new});
	assign st_nx    = head.check_hash ? (hash_bad ? ST_HASH : ST_OK) : head.status;

	// sums restart after every final result, which covers the clear at the next good header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
		end else if (pop) begin
			if (head.last) begin
				a_q <= '0;
				b_q <= '0;
			end else begin
				a_q <= a_new;
				b_q <= b_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (pop) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte       <= head.data;
			byte_kind      <= head.kind;
			frame_end      <= head.last;
			status         <= head.last ? st_nx : ST_OK;
			frame_sequence <= head.seq;
			frame_length   <= head.len;
		end
	end

endmodule

`default_nettype wire

[src/checked_frame_deframer.sv]
// an accepted byte's result goes through the request queue, then the output register
// throughput: one byte per cycle unless stalled; adler-style sums take one byte a cycle
// the request queue lets the parser keep taking bytes while the output is stalled
// reset (arst_n low, asynchronous): parser expects a header, queue and output empty,
// adler sums zero, max_frame_length back to 1048576
`default_nettype none

module checked_frame_deframer import cfd_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // [7:0] out_byte, [10:8] status,
	                                    // [42:11] frame_sequence, [63:43] frame_length
	output logic [1:0]       m_tuser,   // [1:0] byte_kind
	output logic             m_tlast,   // frame_end
	input  wire logic        cfg_wen,
	input  wire logic [20:0] cfg_wdata  // max_frame_length
);

	cmd_t              push_cmd, head_cmd;
	logic              push, pop, q_full, q_empty;
	logic [BYTE_W-1:0] out_byte;
	logic [STAT_W-1:0] status;
	logic [WORD_W-1:0] frame_sequence;
	logic [LEN_W-1:0]  frame_length;

	cfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push),
		.cmd       (push_cmd)
	);

	cfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_cmd),
		.pop     (pop),
		.rd_data (head_cmd),
		.full    (q_full),
		.empty   (q_empty)
	);

	cfd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.head           (head_cmd),
		.pop            (pop),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_byte       (out_byte),
		.byte_kind      (m_tuser),
		.frame_end      (m_tlast),
		.status         (status),
		.frame_sequence (frame_sequence),
		.frame_length   (frame_length)
	);

	assign m_tdata = {frame_length, frame_sequence, status, out_byte};

endmodule

`default_nettype wire

[src/cfd_checker.sv]
`default_nettype none

`include "checked_frame_deframer_assert.svh"

module cfd_checker import cfd_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire logic        m_tlast
);

	logic [66:0] m_word;

	assign m_word = {m_tdata, m_tuser, m_tlast};

	// a stalled result holds
	`CFD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_word))

	// status is only reported on the final result of a frame
	`CFD_ASSERT_IMP(a_status_at_end, m_tvalid && !m_tlast, m_tdata[10:8] == ST_OK)

	// a status-only result always closes the frame and carries no byte
	`CFD_ASSERT_IMP(a_status_only, m_tvalid && m_tuser == KIND_STATUS, m_tlast && m_tdata[7:0] == 8'd0)

endmodule

bind checked_frame_deframer cfd_checker u_cfd_checker (.*);

`default_nettype wire
